@@ design/uart_boot_programmer_macros.svh @@
// Assertion macros used by the port-level checker file
`ifndef UART_BOOT_PROGRAMMER_MACROS_SVH
`define UART_BOOT_PROGRAMMER_MACROS_SVH

// Check a property outside reset
`define UBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included
`define UBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ubp_pkg.sv @@
// Shared constants, types and sizing functions of the bootloader host
`default_nettype none
package ubp_pkg;

  localparam int unsigned IMAGE_DEPTH  = 131072;
  localparam int unsigned IMG_AW       = 17;
  localparam int unsigned CHUNK_BYTES  = 256;
  localparam int unsigned PAGE_SHIFT   = 11;
  localparam int unsigned SECTOR_SHIFT = 12;

  // item opcodes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_RX    = 3'd1;
  localparam logic [2:0] OP_TXRDY = 3'd2;
  localparam logic [2:0] OP_TMO   = 3'd3;
  localparam logic [2:0] OP_LOAD  = 3'd4;

  // commands
  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_ERASE   = 3'd2;
  localparam logic [2:0] CMD_INFO    = 3'd3;
  localparam logic [2:0] CMD_WPROT   = 3'd4;
  localparam logic [2:0] CMD_WUNPROT = 3'd5;
  localparam logic [2:0] CMD_RPROT   = 3'd6;
  localparam logic [2:0] CMD_RUNPROT = 3'd7;

  // end status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RETRY    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_IMAGE_LENGTH = 3'd0;
  localparam logic [2:0] REG_FLASH_KBYTES = 3'd1;
  localparam logic [2:0] REG_VERIFY       = 3'd2;
  localparam logic [2:0] REG_BASE_ADDRESS = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT  = 3'd4;

  // protocol bytes
  localparam logic [7:0] BYTE_ACK      = 8'h79;
  localparam logic [7:0] BYTE_SYNC     = 8'h7F;
  localparam logic [7:0] BYTE_ERASE    = 8'h43;
  localparam logic [7:0] BYTE_MASS     = 8'hFF;
  localparam logic [7:0] BYTE_WRITE    = 8'h31;
  localparam logic [7:0] BYTE_READ     = 8'h11;
  localparam logic [7:0] BYTE_GET_VER  = 8'h01;
  localparam logic [7:0] BYTE_GET_ID   = 8'h02;
  localparam logic [7:0] BYTE_WPROT    = 8'h63;
  localparam logic [7:0] BYTE_WUNPROT  = 8'h73;
  localparam logic [7:0] BYTE_RPROT    = 8'h82;
  localparam logic [7:0] BYTE_RUNPROT  = 8'h92;

  typedef struct packed {
    logic [17:0] image_length;
    logic [7:0]  flash_kbytes;
    logic        verify_after_write;
    logic [31:0] base_address;
    logic [7:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              data_valid;
    logic              data_kind;
    logic [IMG_AW-1:0] data_addr;
    logic [7:0]        data_byte;
    logic              finished;
    logic [1:0]        end_status;
    logic [IMG_AW-1:0] fail_addr;
  } res_t;

  function automatic logic [8:0] chunk_of(input logic [17:0] total, input logic [17:0] offs);
    logic [17:0] rem;
    rem = (total > offs) ? total - offs : '0;
    if (rem == '0) return 9'd1;
    else if (rem < 18'(CHUNK_BYTES)) return rem[8:0];
    else return 9'(CHUNK_BYTES);
  endfunction

  function automatic logic [8:0] list_count(input logic [17:0] bytes, input int unsigned shift);
    logic [18:0] sum;
    logic [18:0] q;
    sum = {1'b0, bytes} + ((19'd1 << shift) - 19'd1);
    q = sum >> shift;
    if (q == '0) return 9'd1;
    else if (q > 19'd256) return 9'd256;
    else return q[8:0];
  endfunction

endpackage
`default_nettype wire

@@ design/ubp_image_ram.sv @@
// Image byte store: one write port, one registered read port with write bypass
`default_nettype none
module ubp_image_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ubp_pkg::IMG_AW-1:0] wa,
  input  wire logic [7:0]                 wd,
  input  wire logic [ubp_pkg::IMG_AW-1:0] ra,
  output logic      [7:0]                 rq
);
  logic [7:0] mem [ubp_pkg::IMAGE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  // forward a same-cycle write to the entry being read
  always_ff @(posedge clk) begin
    if (we && (wa == ra)) rq <= wd;
    else rq <= mem[ra];
  end
endmodule
`default_nettype wire

@@ design/ubp_ctrl.sv @@
// Protocol sequencer: phase state, frame building, ACK checks, image fetch
`default_nettype none
module ubp_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic [2:0]                 op,
  input  wire logic [2:0]                 command,
  input  wire logic [7:0]                 rx_byte,
  input  wire logic [ubp_pkg::IMG_AW-1:0] image_addr,
  input  wire logic [7:0]                 image_byte,
  input  wire ubp_pkg::cfg_t              cfg,
  output ubp_pkg::res_t                   res,
  output logic                            res_have
);
  localparam logic [3:0] P_IDLE    = 4'd0;
  localparam logic [3:0] P_SYNC    = 4'd1;
  localparam logic [3:0] P_ER_CMD  = 4'd2;
  localparam logic [3:0] P_ER_ARG  = 4'd3;
  localparam logic [3:0] P_WR_CMD  = 4'd4;
  localparam logic [3:0] P_WR_ADDR = 4'd5;
  localparam logic [3:0] P_WR_DATA = 4'd6;
  localparam logic [3:0] P_RD_CMD  = 4'd7;
  localparam logic [3:0] P_RD_ADDR = 4'd8;
  localparam logic [3:0] P_RD_LEN  = 4'd9;
  localparam logic [3:0] P_VER     = 4'd10;
  localparam logic [3:0] P_ID      = 4'd11;
  localparam logic [3:0] P_WP_CMD  = 4'd12;
  localparam logic [3:0] P_WP_ARG  = 4'd13;
  localparam logic [3:0] P_UNP     = 4'd14;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  oper_r, oper_nxt;
  logic        synced_r, synced_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic [17:0] fo_r, fo_nxt;
  logic [8:0]  fi_r, fi_nxt;
  logic [7:0]  cs_r, cs_nxt;
  logic [8:0]  rxc_r, rxc_nxt;
  logic [7:0]  idlen_r, idlen_nxt;

  logic [7:0]  mem_q;
  logic [17:0] rd_full;
  logic        ram_we;

  logic [17:0] img_len, flash_bytes, rd_total, xfer_len;
  logic [8:0]  chunk_w, chunk_x, page_cnt, sec_cnt, frame_len;
  logic        has_cs, cs_last;
  logic [7:0]  first_code, body, tx_b;
  logic [31:0] addr_word;
  logic [7:0]  retry_sat;
  logic        gives_up;
  logic [3:0]  retry_tgt, begin_ph;

  logic        go_en, fin_en, fail_en;
  logic [3:0]  go_ph;
  logic [1:0]  fin_st;
  logic [17:0] fin_fa;
  logic        ack;
  logic [17:0] fo_sum, rd_a;

  assign ram_we = take && (op == ubp_pkg::OP_LOAD);

  ubp_image_ram u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (image_addr),
    .wd  (image_byte),
    .ra  (rd_full[ubp_pkg::IMG_AW-1:0]),
    .rq  (mem_q)
  );

  // sizes from the registers
  always_comb begin
    img_len = cfg.image_length;
    if (img_len == '0) img_len = 18'd1;
    if (img_len > 18'(ubp_pkg::IMAGE_DEPTH)) img_len = 18'(ubp_pkg::IMAGE_DEPTH);
    flash_bytes = {((cfg.flash_kbytes == '0) ? 8'd1 : cfg.flash_kbytes), 10'd0};
    rd_total = (flash_bytes > 18'(ubp_pkg::IMAGE_DEPTH)) ? 18'(ubp_pkg::IMAGE_DEPTH)
                                                         : flash_bytes;
    xfer_len = (oper_r == ubp_pkg::CMD_READ) ? rd_total : img_len;
  end

  assign chunk_w  = ubp_pkg::chunk_of(img_len, fo_r);
  assign chunk_x  = ubp_pkg::chunk_of(xfer_len, fo_r);
  assign page_cnt = ubp_pkg::list_count(img_len, ubp_pkg::PAGE_SHIFT);
  assign sec_cnt  = ubp_pkg::list_count(flash_bytes, ubp_pkg::SECTOR_SHIFT);
  assign addr_word = cfg.base_address + {14'd0, fo_r};

  always_comb begin
    case (phase_r)
      P_IDLE:               frame_len = 9'd0;
      P_SYNC:               frame_len = 9'd1;
      P_WR_ADDR, P_RD_ADDR: frame_len = 9'd5;
      P_ER_ARG:  frame_len = (oper_r == ubp_pkg::CMD_WRITE) ? page_cnt + 9'd2 : 9'd2;
      P_WP_ARG:  frame_len = sec_cnt + 9'd2;
      P_WR_DATA: frame_len = chunk_w + 9'd2;
      default:   frame_len = 9'd2;
    endcase
  end

  assign has_cs = (phase_r == P_WR_ADDR) || (phase_r == P_RD_ADDR) ||
                  (phase_r == P_WR_DATA) || (phase_r == P_WP_ARG) ||
                  ((phase_r == P_ER_ARG) && (oper_r == ubp_pkg::CMD_WRITE));
  assign cs_last = has_cs && (({1'b0, fi_r} + 10'd1) == {1'b0, frame_len});

  always_comb begin
    case (phase_r)
      P_ER_CMD: first_code = ubp_pkg::BYTE_ERASE;
      P_ER_ARG: first_code = ubp_pkg::BYTE_MASS;
      P_WR_CMD: first_code = ubp_pkg::BYTE_WRITE;
      P_RD_CMD: first_code = ubp_pkg::BYTE_READ;
      P_RD_LEN: first_code = 8'(chunk_x - 9'd1);
      P_VER:    first_code = ubp_pkg::BYTE_GET_VER;
      P_ID:     first_code = ubp_pkg::BYTE_GET_ID;
      P_WP_CMD: first_code = ubp_pkg::BYTE_WPROT;
      default: begin
        if (oper_r == ubp_pkg::CMD_WUNPROT) first_code = ubp_pkg::BYTE_WUNPROT;
        else if (oper_r == ubp_pkg::CMD_RPROT) first_code = ubp_pkg::BYTE_RPROT;
        else first_code = ubp_pkg::BYTE_RUNPROT;
      end
    endcase
  end

  always_comb begin
    body = (fi_r == '0) ? first_code : ~first_code;
    case (phase_r)
      P_SYNC: body = ubp_pkg::BYTE_SYNC;
      P_WR_ADDR, P_RD_ADDR: begin
        case (fi_r[1:0])
          2'd0:    body = addr_word[31:24];
          2'd1:    body = addr_word[23:16];
          2'd2:    body = addr_word[15:8];
          default: body = addr_word[7:0];
        endcase
      end
      P_WP_ARG: body = (fi_r == '0) ? 8'(sec_cnt - 9'd1) : 8'(fi_r - 9'd1);
      P_WR_DATA: body = (fi_r == '0) ? 8'(chunk_w - 9'd1) : mem_q;
      P_ER_ARG: begin
        if (oper_r == ubp_pkg::CMD_WRITE)
          body = (fi_r == '0) ? 8'(page_cnt - 9'd1) : 8'(fi_r - 9'd1);
      end
      default: ;
    endcase
  end

  assign tx_b = cs_last ? cs_r : body;

  assign retry_sat = (retry_r == 8'hFF) ? 8'hFF : retry_r + 8'd1;
  assign gives_up  = retry_sat >= cfg.retry_limit;

  always_comb begin
    case (phase_r)
      P_ER_CMD, P_ER_ARG:               retry_tgt = P_ER_CMD;
      P_WR_CMD, P_WR_ADDR, P_WR_DATA:   retry_tgt = P_WR_CMD;
      P_RD_CMD, P_RD_ADDR, P_RD_LEN:    retry_tgt = P_RD_CMD;
      P_WP_CMD, P_WP_ARG:               retry_tgt = P_WP_CMD;
      default:                          retry_tgt = phase_r;
    endcase
  end

  always_comb begin
    logic [2:0] o;
    o = (op == ubp_pkg::OP_START && phase_r == P_IDLE) ? command : oper_r;
    case (o)
      ubp_pkg::CMD_WRITE, ubp_pkg::CMD_ERASE: begin_ph = P_ER_CMD;
      ubp_pkg::CMD_READ:  begin_ph = P_RD_CMD;
      ubp_pkg::CMD_INFO:  begin_ph = P_VER;
      ubp_pkg::CMD_WPROT: begin_ph = P_WP_CMD;
      default:            begin_ph = P_UNP;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    oper_nxt   = oper_r;
    synced_nxt = synced_r;
    retry_nxt  = retry_r;
    fo_nxt     = fo_r;
    fi_nxt     = fi_r;
    cs_nxt     = cs_r;
    rxc_nxt    = rxc_r;
    idlen_nxt  = idlen_r;
    res        = '0;
    res_have   = 1'b0;
    go_en      = 1'b0;
    go_ph      = P_IDLE;
    fin_en     = 1'b0;
    fin_st     = ubp_pkg::ST_OK;
    fin_fa     = '0;
    fail_en    = 1'b0;
    ack        = (rx_byte == ubp_pkg::BYTE_ACK);
    fo_sum     = '0;
    rd_a       = fo_r + {9'd0, rxc_r} - 18'd1;

    if (take) begin
      case (op)
        ubp_pkg::OP_START: begin
          if (phase_r == P_IDLE) begin
            oper_nxt  = command;
            retry_nxt = '0;
            go_en = 1'b1;
            if (!synced_r) go_ph = P_SYNC;
            else begin
              go_ph = begin_ph;
              if (command == ubp_pkg::CMD_READ) fo_nxt = '0;
            end
          end
        end
        ubp_pkg::OP_RX: begin
          if (phase_r != P_IDLE && fi_r >= frame_len) begin
            rxc_nxt = rxc_r + 9'd1;
            case (phase_r)
              P_SYNC: begin
                if (!ack) fail_en = 1'b1;
                else begin
                  synced_nxt = 1'b1;
                  retry_nxt = '0;
                  go_en = 1'b1;
                  go_ph = begin_ph;
                  if (oper_r == ubp_pkg::CMD_READ) fo_nxt = '0;
                end
              end
              P_ER_CMD, P_WR_CMD, P_WR_ADDR, P_RD_CMD, P_RD_ADDR, P_WP_CMD: begin
                if (!ack) fail_en = 1'b1;
                else begin
                  retry_nxt = '0;
                  go_en = 1'b1;
                  go_ph = phase_r + 4'd1;
                end
              end
              P_ER_ARG: begin
                if (!ack) fail_en = 1'b1;
                else if (oper_r != ubp_pkg::CMD_WRITE) begin
                  retry_nxt = '0;
                  fin_en = 1'b1;
                end else begin
                  fo_nxt = '0;
                  retry_nxt = '0;
                  go_en = 1'b1;
                  go_ph = P_WR_CMD;
                end
              end
              P_WR_DATA: begin
                fo_sum = fo_r + {9'd0, chunk_w};
                if (!ack) fail_en = 1'b1;
                else begin
                  retry_nxt = '0;
                  if (fo_sum < img_len) begin
                    fo_nxt = fo_sum;
                    go_en = 1'b1;
                    go_ph = P_WR_CMD;
                  end else if (cfg.verify_after_write) begin
                    fo_nxt = '0;
                    go_en = 1'b1;
                    go_ph = P_RD_CMD;
                  end else begin
                    fo_nxt = fo_sum;
                    fin_en = 1'b1;
                  end
                end
              end
              P_RD_LEN: begin
                fo_sum = fo_r + {9'd0, chunk_x};
                if (rxc_r == '0) begin
                  if (!ack) fail_en = 1'b1;
                end else begin
                  if (oper_r == ubp_pkg::CMD_READ) begin
                    res.data_valid = 1'b1;
                    res.data_kind  = 1'b0;
                    res.data_addr  = rd_a[ubp_pkg::IMG_AW-1:0];
                    res.data_byte  = rx_byte;
                    res_have = 1'b1;
                  end
                  if (oper_r != ubp_pkg::CMD_READ && mem_q != rx_byte) begin
                    fin_en = 1'b1;
                    fin_st = ubp_pkg::ST_MISMATCH;
                    fin_fa = rd_a;
                  end else if (rxc_r >= chunk_x) begin
                    retry_nxt = '0;
                    fo_nxt = fo_sum;
                    if (fo_sum >= xfer_len) fin_en = 1'b1;
                    else begin
                      go_en = 1'b1;
                      go_ph = P_RD_CMD;
                    end
                  end
                end
              end
              P_VER: begin
                if (rxc_r == '0) begin
                  if (!ack) fail_en = 1'b1;
                end else if (rxc_r <= 9'd3) begin
                  res.data_valid = 1'b1;
                  res.data_kind  = 1'b1;
                  res.data_addr  = 17'(rxc_r - 9'd1);
                  res.data_byte  = rx_byte;
                  res_have = 1'b1;
                end else if (!ack) fail_en = 1'b1;
                else begin
                  retry_nxt = '0;
                  go_en = 1'b1;
                  go_ph = P_ID;
                end
              end
              P_ID: begin
                if (rxc_r == '0) begin
                  if (!ack) fail_en = 1'b1;
                end else if (rxc_r == 9'd1) begin
                  idlen_nxt = rx_byte;
                end else if ({1'b0, rxc_r} <= ({2'd0, idlen_r} + 10'd2)) begin
                  res.data_valid = 1'b1;
                  res.data_kind  = 1'b1;
                  res.data_addr  = 17'({1'b0, rxc_r} + 10'd1);
                  res.data_byte  = rx_byte;
                  res_have = 1'b1;
                end else if (!ack) fail_en = 1'b1;
                else begin
                  retry_nxt = '0;
                  fin_en = 1'b1;
                end
              end
              P_WP_ARG, P_UNP: begin
                if (!ack) fail_en = 1'b1;
                else if (!(phase_r == P_UNP && rxc_r == '0)) begin
                  retry_nxt = '0;
                  fin_en = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ubp_pkg::OP_TXRDY: begin
          if (phase_r != P_IDLE && fi_r < frame_len) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_b;
            res_have = 1'b1;
            if (!cs_last) cs_nxt = (fi_r == '0) ? body : (cs_r ^ body);
            fi_nxt = fi_r + 9'd1;
          end
        end
        ubp_pkg::OP_TMO: begin
          if (phase_r != P_IDLE) begin
            fin_en = 1'b1;
            fin_st = ubp_pkg::ST_TIMEOUT;
          end
        end
        default: ;
      endcase
    end

    if (fail_en) begin
      retry_nxt = retry_sat;
      if (gives_up) begin
        fin_en = 1'b1;
        fin_st = ubp_pkg::ST_RETRY;
        fin_fa = '0;
      end else begin
        go_en = 1'b1;
        go_ph = retry_tgt;
      end
    end
    if (fin_en) begin
      go_en = 1'b1;
      go_ph = P_IDLE;
      res.finished   = 1'b1;
      res.end_status = fin_st;
      res.fail_addr  = fin_fa[ubp_pkg::IMG_AW-1:0];
      res_have = 1'b1;
    end
    if (go_en) begin
      phase_nxt = go_ph;
      fi_nxt    = '0;
      rxc_nxt   = '0;
      cs_nxt    = '0;
    end
  end

  // prefetch the image byte the next beat may need
  assign rd_full = (phase_nxt == P_WR_DATA) ? fo_nxt + {9'd0, fi_nxt} - 18'd1
                                            : fo_nxt + {9'd0, rxc_nxt} - 18'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= P_IDLE;
      oper_r   <= '0;
      synced_r <= 1'b0;
      retry_r  <= '0;
      fo_r     <= '0;
      fi_r     <= '0;
      cs_r     <= '0;
      rxc_r    <= '0;
      idlen_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      oper_r   <= oper_nxt;
      synced_r <= synced_nxt;
      retry_r  <= retry_nxt;
      fo_r     <= fo_nxt;
      fi_r     <= fi_nxt;
      cs_r     <= cs_nxt;
      rxc_r    <= rxc_nxt;
      idlen_r  <= idlen_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/uart_boot_programmer.sv @@
// Top level of the UART bootloader host: config registers, output beat register
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | op, command, rx_byte, image_addr, image_byte
//  out_    | out | out_valid/out_stall| tx, data, finished fields
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input beat per cycle while in_stall is low; each beat is fully handled in the cycle it is taken.
// Image bytes come from a synchronous store with a registered read, prefetched at the address
// the following beat may need, with bypass of a same-cycle image write.
// Results sit in one output register; input stalls only while that register is
// full and stalled. Synchronous reset clears control state; no clearing pass.
`default_nettype none
module uart_boot_programmer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 in_op,
  input  wire logic [2:0]                 in_command,
  input  wire logic [7:0]                 in_rx_byte,
  input  wire logic [ubp_pkg::IMG_AW-1:0] in_image_addr,
  input  wire logic [7:0]                 in_image_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_tx_valid,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_data_valid,
  output logic                            out_data_kind,
  output logic [ubp_pkg::IMG_AW-1:0]      out_data_addr,
  output logic [7:0]                      out_data_byte,
  output logic                            out_finished,
  output logic [1:0]                      out_end_status,
  output logic [ubp_pkg::IMG_AW-1:0]      out_fail_addr,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [31:0]                cfg_data
);
  ubp_pkg::cfg_t cfg_r;
  ubp_pkg::res_t res, res_r;
  logic          res_have;
  logic          out_valid_r;
  logic          take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_length       <= 18'd1;
      cfg_r.flash_kbytes       <= 8'd64;
      cfg_r.verify_after_write <= 1'b1;
      cfg_r.base_address       <= 32'h0800_0000;
      cfg_r.retry_limit        <= 8'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        ubp_pkg::REG_IMAGE_LENGTH: cfg_r.image_length       <= cfg_data[17:0];
        ubp_pkg::REG_FLASH_KBYTES: cfg_r.flash_kbytes       <= cfg_data[7:0];
        ubp_pkg::REG_VERIFY:       cfg_r.verify_after_write <= cfg_data[0];
        ubp_pkg::REG_BASE_ADDRESS: cfg_r.base_address       <= cfg_data;
        ubp_pkg::REG_RETRY_LIMIT:  cfg_r.retry_limit        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ubp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .op         (in_op),
    .command    (in_command),
    .rx_byte    (in_rx_byte),
    .image_addr (in_image_addr),
    .image_byte (in_image_byte),
    .cfg        (cfg_r),
    .res        (res),
    .res_have   (res_have)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (take && res_have) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  // hold the beat while stalled
  always_ff @(posedge clk) begin
    if (take && res_have) res_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_tx_valid   = res_r.tx_valid;
  assign out_tx_byte    = res_r.tx_byte;
  assign out_data_valid = res_r.data_valid;
  assign out_data_kind  = res_r.data_kind;
  assign out_data_addr  = res_r.data_addr;
  assign out_data_byte  = res_r.data_byte;
  assign out_finished   = res_r.finished;
  assign out_end_status = res_r.end_status;
  assign out_fail_addr  = res_r.fail_addr;
endmodule
`default_nettype wire

@@ design/ubp_checker.sv @@
// Port-level checker for the bootloader host, bound to the top level
`default_nettype none
`include "uart_boot_programmer_macros.svh"
module ubp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       out_tx_valid,
  input wire logic [7:0]                 out_tx_byte,
  input wire logic                       out_data_valid,
  input wire logic                       out_finished,
  input wire logic [1:0]                 out_end_status,
  input wire logic [ubp_pkg::IMG_AW-1:0] out_fail_addr
);
  `UBP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output beat after reset")
  `UBP_ASSERT(a_stall_only_full, in_stall |-> (out_valid && out_stall), "stall without held beat")
  `UBP_ASSERT(a_tx_data_excl, out_valid |-> !(out_tx_valid && out_data_valid), "tx and data in one beat")
  `UBP_ASSERT(a_fail_addr_zero, (out_valid && out_finished && (out_end_status != ubp_pkg::ST_MISMATCH)) |-> (out_fail_addr == '0), "fail address without mismatch")
  `UBP_ASSERT(a_hold_tx, (out_valid && out_stall) |=> (out_valid && $stable(out_tx_byte)), "stalled beat changed")
endmodule

bind uart_boot_programmer ubp_checker u_ubp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_tx_valid   (out_tx_valid),
  .out_tx_byte    (out_tx_byte),
  .out_data_valid (out_data_valid),
  .out_finished   (out_finished),
  .out_end_status (out_end_status),
  .out_fail_addr  (out_fail_addr)
);
`default_nettype wire
